[sv/bol_pkg.sv]
package bol_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 32;
    localparam int COUNT_W   = 5;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_POP_TAIL = 2'd2,
        CMD_CLEAR    = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                     command;
        logic signed [VAL_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic                     ok;
        logic signed [VAL_W-1:0]  removed_value;
        logic [COUNT_W-1:0]       count;
    } t_out_item;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic                     insert_en;
        logic                     remove_en;
        logic signed [VAL_W-1:0]  key;
    } t_bol_ctl;

endpackage

[sv/bol_cell.sv]
module bol_cell
    import bol_pkg::*;
#(
    parameter int IDX     = 0,
    parameter int COUNT_W = 5
) (
    input  logic                     i_clk,
    input  t_bol_ctl                 i_ctl,
    input  logic [COUNT_W-1:0]       i_count,
    input  logic signed [VAL_W-1:0]  i_left,
    input  logic signed [VAL_W-1:0]  i_right,
    input  logic                     i_found,
    input  logic signed [VAL_W-1:0]  i_tail_acc,
    output logic signed [VAL_W-1:0]  o_entry,
    output logic                     o_found,
    output logic signed [VAL_W-1:0]  o_tail_acc
);

    logic signed [VAL_W-1:0] r_entry;
    logic signed [VAL_W-1:0] n_entry;
    logic                    w_valid;
    logic                    w_tail;

    assign w_valid    = COUNT_W'(IDX) < i_count;
    assign w_tail     = COUNT_W'(IDX + 1) == i_count;
    // match somewhere at or ahead of this place
    assign o_found    = i_found | (w_valid && (r_entry == i_ctl.key));
    assign o_tail_acc = i_tail_acc | (w_tail ? r_entry : '0);
    assign o_entry    = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.insert_en) begin
            n_entry = i_left;
        end else if (i_ctl.remove_en && o_found) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

[sv/bounded_ordered_list.sv]
// result item registered, shown in the cycle after the input item is accepted
// throughput: one item per cycle while the output side takes results; match search and tail pick ripple through
// the row of DEPTH cells within that cycle, and the cells that move all shift together
// reset: synchronous active low, input not ready, entry count and output valid cleared,
// cell contents left as they are (never read before written)
module bounded_ordered_list
    import bol_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                    w_accept;
    logic                    w_full;
    t_bol_ctl                w_ctl;

    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_out_valid;
    logic                    n_out_valid;
    t_out_item               r_out_item;
    t_out_item               n_out_item;

    // chain links between neighbouring cells
    logic signed [VAL_W-1:0] w_entry [DEPTH];
    logic                    w_found [DEPTH+1];
    logic signed [VAL_W-1:0] w_tail  [DEPTH+1];

    // the output register parts the sides: a new item enters while the
    // previous result is being taken; nothing is taken while in reset
    assign o_in_ready = i_rst_n && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = r_count == CW'(DEPTH);

    assign w_ctl.insert_en = w_accept && (i_in_item.command == CMD_INSERT) && !w_full;
    assign w_ctl.remove_en = w_accept && (i_in_item.command == CMD_REMOVE);
    assign w_ctl.key       = i_in_item.value;

    assign w_found[0] = 1'b0;
    assign w_tail[0]  = '0;

    // position 0 is the front; insert feeds the new value into it and every
    // cell takes its front neighbour, a removal pulls from the back neighbour
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic signed [VAL_W-1:0] w_left;
        logic signed [VAL_W-1:0] w_right;

        if (k == 0) begin : g_front
            assign w_left = i_in_item.value;
        end else begin : g_mid
            assign w_left = w_entry[k-1];
        end

        // the last cell holds no valid entry after a removal, so any data will do
        if (k == DEPTH - 1) begin : g_back
            assign w_right = w_entry[k];
        end else begin : g_inner
            assign w_right = w_entry[k+1];
        end

        bol_cell #(
            .IDX     (k),
            .COUNT_W (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_count    (r_count),
            .i_left     (w_left),
            .i_right    (w_right),
            .i_found    (w_found[k]),
            .i_tail_acc (w_tail[k]),
            .o_entry    (w_entry[k]),
            .o_found    (w_found[k+1]),
            .o_tail_acc (w_tail[k+1])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        if (w_accept) begin
            n_out_valid              = 1'b1;
            n_out_item.ok            = 1'b0;
            n_out_item.removed_value = '0;
            unique case (i_in_item.command)
                CMD_INSERT: begin
                    // full list stands for an allocation failure
                    if (!w_full) begin
                        n_count       = r_count + CW'(1);
                        n_out_item.ok = 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    if (w_found[DEPTH]) begin
                        n_count       = r_count - CW'(1);
                        n_out_item.ok = 1'b1;
                    end
                end
                CMD_POP_TAIL: begin
                    if (r_count != '0) begin
                        n_count                  = r_count - CW'(1);
                        n_out_item.ok            = 1'b1;
                        n_out_item.removed_value = w_tail[DEPTH];
                    end
                end
                CMD_CLEAR: begin
                    n_count       = '0;
                    n_out_item.ok = 1'b1;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
            // count field carries the low bits only
            n_out_item.count = COUNT_W'({{COUNT_W{1'b0}}, n_count});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[tb/bounded_ordered_list_test.sv]
module bounded_ordered_list_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bol_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 1400;
    // far above the slowest legal run of ~1450 items
    localparam int CYCLE_LIMIT  = 400000;
    // result is registered in the cycle after acceptance, so a short tail is plenty
    localparam int TAIL_CYCLES  = 8;

    // dut inputs, all known from time zero
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    // stimulus not yet offered, and replies predicted but not yet seen
    t_in_item  queued_cmds [$];
    t_out_item pending_replies [$];

    // shadow copy of the list, front at index 0
    logic signed [VAL_W-1:0] shadow_vals [LIST_DEPTH];
    int                      shadow_len  = 0;

    int  accepted_total = 0;
    int  results_seen   = 0;
    int  fail_count     = 0;
    int  total_items    = 0;
    int  directed_len   = 0;
    int  cycle_count    = 0;
    logic draining      = 1'b0;

    bounded_ordered_list #(
        .DEPTH(LIST_DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // apply one command to the shadow list and return the reply it should give
    function automatic t_out_item apply_list_cmd(t_in_item cmd_item);
        t_out_item reply;
        int        hit;
        reply.ok            = 1'b0;
        reply.removed_value = '0;
        hit                 = -1;
        case (cmd_item.command)
            CMD_INSERT: begin
                // full list: insert refused, nothing moves
                if (shadow_len < LIST_DEPTH) begin
                    for (int i = shadow_len; i > 0; i--) shadow_vals[i] = shadow_vals[i-1];
                    shadow_vals[0] = cmd_item.value;
                    shadow_len++;
                    reply.ok = 1'b1;
                end
            end
            CMD_REMOVE: begin
                // nearest match to the front wins; a miss leaves the list alone
                for (int i = 0; i < shadow_len; i++) begin
                    if (hit < 0 && shadow_vals[i] == cmd_item.value) hit = i;
                end
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < shadow_len; i++) shadow_vals[i] = shadow_vals[i+1];
                    shadow_len--;
                    reply.ok = 1'b1;
                end
            end
            CMD_POP_TAIL: begin
                // empty list: refused, removed value stays zero
                if (shadow_len > 0) begin
                    shadow_len--;
                    reply.removed_value = shadow_vals[shadow_len];
                    reply.ok            = 1'b1;
                end
            end
            default: begin
                // clear always succeeds, empty list included
                shadow_len = 0;
                reply.ok   = 1'b1;
            end
        endcase
        reply.count = COUNT_W'(shadow_len);
        return reply;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at reply %0d: %s got %0h want %0h", results_seen, what, got, want);
        fail_count++;
    endtask

    // idling plan: sender light and receiver heavy, then swapped, then none
    function automatic int sender_idle_pct();
        if (accepted_total < total_items / 3)     return 26;
        if (accepted_total < 2 * total_items / 3) return 88;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (accepted_total < total_items / 3)     return 88;
        if (accepted_total < 2 * total_items / 3) return 26;
        return 0;
    endfunction

    // reset sequencing and the run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RESET_CYCLES - 1) i_rst_n <= 1'b1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // sender: predicts on acceptance, holds valid until taken
    always @(posedge i_clk) begin : drive_proc
        logic     fire;
        logic     next_valid;
        t_in_item next_item;
        int       n_acc;
        fire       = i_in_valid && o_in_ready;
        next_valid = i_in_valid;
        next_item  = i_in_item;
        n_acc      = accepted_total;
        if (fire) begin
            pending_replies.push_back(apply_list_cmd(i_in_item));
            n_acc++;
            next_valid = 1'b0;
            // hold off after the directed part and halfway through, until all replies are in
            if (n_acc == directed_len || n_acc == total_items / 2) draining = 1'b1;
        end
        if (draining && results_seen == n_acc) draining = 1'b0;
        if (!next_valid && i_rst_n && !draining && queued_cmds.size() != 0
                && $urandom_range(99) >= sender_idle_pct()) begin
            next_item  = queued_cmds.pop_front();
            next_valid = 1'b1;
        end
        i_in_valid     <= next_valid;
        i_in_item      <= next_item;
        accepted_total <= n_acc;
    end

    // receiver: random back-pressure, field by field compare against the oldest prediction
    always @(posedge i_clk) begin : watch_proc
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            // accepted_total still holds the count before this edge, so a waiting
            // prediction exists exactly when it is ahead of the replies seen
            if (results_seen >= accepted_total) begin
                report_mismatch("unexpected reply", 64'(o_out_item), 64'd0);
            end else begin
                want = pending_replies.pop_front();
                if (o_out_item.ok !== want.ok)
                    report_mismatch("ok", 64'(o_out_item.ok), 64'(want.ok));
                if (o_out_item.removed_value !== want.removed_value)
                    report_mismatch("removed_value", 64'(o_out_item.removed_value),
                                    64'(want.removed_value));
                if (o_out_item.count !== want.count)
                    report_mismatch("count", 64'(o_out_item.count), 64'(want.count));
                results_seen <= results_seen + 1;
            end
        end
        i_out_ready <= ($urandom_range(99) >= receiver_idle_pct());
    end

    task automatic queue_cmd(t_cmd command, logic signed [VAL_W-1:0] value);
        t_in_item item;
        item.command = command;
        item.value   = value;
        queued_cmds.push_back(item);
    endtask

    // small pool so that removes hit and duplicates occur
    function automatic logic signed [VAL_W-1:0] pick_value(int pool_pct);
        logic signed [VAL_W-1:0] pool [8];
        pool = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1,
                 32'sd1, 32'sd5, 32'sh5555_5555, 32'shaaaa_aaaa};
        if ($urandom_range(99) < pool_pct) return pool[$urandom_range(7)];
        return $urandom;
    endfunction

    initial begin : stimulus_proc
        int   mode;
        int   burst;
        int   roll;
        t_cmd cmd;

        // empty-list corner cases
        queue_cmd(CMD_CLEAR,    32'sd0);
        queue_cmd(CMD_POP_TAIL, 32'sd0);
        queue_cmd(CMD_REMOVE,   32'sd0);
        // fill to the brim with extremes and duplicates, then one insert too many
        queue_cmd(CMD_INSERT, 32'sh8000_0000);
        queue_cmd(CMD_INSERT, 32'sh7fff_ffff);
        queue_cmd(CMD_INSERT, 32'sd0);
        queue_cmd(CMD_INSERT, -32'sd1);
        queue_cmd(CMD_INSERT, 32'sd7);
        queue_cmd(CMD_INSERT, 32'sd7);
        queue_cmd(CMD_INSERT, 32'sh5555_5555);
        queue_cmd(CMD_INSERT, 32'shaaaa_aaaa);
        queue_cmd(CMD_INSERT, 32'sd7);
        for (int v = 1; v <= 7; v++) queue_cmd(CMD_INSERT, 32'(v * 11));
        queue_cmd(CMD_INSERT, 32'sd9);
        // duplicate removal, miss, tail returns the most negative value, removal of the most positive, then clear
        queue_cmd(CMD_REMOVE,   32'sd7);
        queue_cmd(CMD_REMOVE,   32'sd12345);
        queue_cmd(CMD_POP_TAIL, 32'sd0);
        queue_cmd(CMD_REMOVE,   32'sh7fff_ffff);
        queue_cmd(CMD_CLEAR,    32'sd0);
        directed_len = queued_cmds.size();

        // random bursts: filling, emptying, mixed, and raw noise
        while (queued_cmds.size() < directed_len + RANDOM_ITEMS) begin
            mode  = $urandom_range(3);
            burst = $urandom_range(32, 8);
            for (int n = 0; n < burst; n++) begin
                roll = $urandom_range(99);
                case (mode)
                    0: cmd = (roll < 75) ? CMD_INSERT : (roll < 87) ? CMD_REMOVE
                           : (roll < 98) ? CMD_POP_TAIL : CMD_CLEAR;
                    1: cmd = (roll < 20) ? CMD_INSERT : (roll < 58) ? CMD_REMOVE
                           : (roll < 97) ? CMD_POP_TAIL : CMD_CLEAR;
                    2: cmd = (roll < 45) ? CMD_INSERT : (roll < 70) ? CMD_REMOVE
                           : (roll < 98) ? CMD_POP_TAIL : CMD_CLEAR;
                    default: cmd = t_cmd'($urandom_range(3));
                endcase
                if (mode == 3)
                    queue_cmd(cmd, $urandom);
                else if (cmd == CMD_REMOVE)
                    queue_cmd(cmd, pick_value(85));
                else
                    queue_cmd(cmd, pick_value(60));
            end
        end
        total_items = queued_cmds.size();

        // wait until everything is offered, taken and answered
        do @(negedge i_clk);
        while (queued_cmds.size() != 0 || i_in_valid || results_seen != accepted_total);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (pending_replies.size() != 0)
            report_mismatch("replies left over", 64'(pending_replies.size()), 64'd0);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[bounded_ordered_list.f]
sv/bol_pkg.sv
sv/bol_cell.sv
sv/bounded_ordered_list.sv
tb/bounded_ordered_list_test.sv
